FILE: rtl/cbe_pkg.sv
// Shared constants and widths for the cubic Bezier easing unit.
package cbe_pkg;

  localparam int ONE_Q16 = 65536;
  localparam int DEF_TABLE_SIZE = 17;
  localparam int DEF_NEWTON_STEPS = 4;

  // shared multiplier operand widths
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 18;

  // shared divider widths
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_X1 = 3'd0;
  localparam logic [2:0] REG_Y1 = 3'd1;
  localparam logic [2:0] REG_X2 = 3'd2;
  localparam logic [2:0] REG_Y2 = 3'd3;
  localparam logic [2:0] REG_HOLD = 3'd4;

endpackage

FILE: rtl/cbe_mul.sv
// Shared Q16 multiplier: registered product, rounded to nearest (ties up).
module cbe_mul (
  input  logic                                clk,
  input  logic signed [cbe_pkg::MUL_AW-1:0]   a,
  input  logic signed [cbe_pkg::MUL_BW-1:0]   b,
  output logic signed [cbe_pkg::MUL_AW-1:0]   r
);

  localparam int PW = cbe_pkg::MUL_AW + cbe_pkg::MUL_BW;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;

  always_ff @(posedge clk) begin
    prod <= PW'(a) * PW'(b);
  end

  assign rnd = prod + PW'(32768);
  assign r = cbe_pkg::MUL_AW'(rnd >>> 16);

endmodule

FILE: rtl/cbe_div.sv
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
module cbe_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [cbe_pkg::DIV_NW-1:0]  num,
  input  logic signed [cbe_pkg::DIV_DW-1:0]  den,
  output logic                               busy,
  output logic                               done,
  output logic signed [cbe_pkg::DIV_NW-1:0]  quot
);

  localparam int NW = cbe_pkg::DIV_NW;
  localparam int DW = cbe_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] dmag;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  assign rem_sh  = {rem[DW-1:0], q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        q    <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag <= den[DW-1] ? DW'(-den) : DW'(den);
        neg  <= num[NW-1] ^ den[DW-1];
        rem  <= '0;
      end else if (busy) begin
        if (!rem_sub[DW]) begin
          rem <= rem_sub;
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);

endmodule

FILE: rtl/cubic_bezier_easing_unit.sv
// Cubic Bezier easing unit: top level with register port, sequencer and sample table.
//
// Evaluates a CSS style cubic-bezier easing curve (end points (0,0) and (1,1)) at one
// progress value per transfer, in Q16 (1.0 = 65536). Hold mode or progress <= 0 gives 0,
// progress >= 1 gives 1.0, and a linear curve passes progress through. These answers are
// offered in the cycle after acceptance. Otherwise the sequencer solves Bx(t) = x and
// returns By(t), using one shared multiplier and one shared bit-serial divider. The
// divider computes the segment offset and the update inside each Newton step; a
// zero-width segment skips the offset division, and a step that finds a slope that is
// not positive ends the refinement. The divisions by TABLE_SIZE-1 use a constant
// reciprocal multiply and take no divider time. After a write to any of the five
// registers the first curve item also rebuilds the TABLE_SIZE-point table of Bx. One
// item is in work at a time: s_tready is low from acceptance until the result transfer
// completes.
module cubic_bezier_easing_unit #(
  parameter int TABLE_SIZE   = cbe_pkg::DEF_TABLE_SIZE,
  parameter int NEWTON_STEPS = cbe_pkg::DEF_NEWTON_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [18:0] progress, [23:19] zero
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [18:0] eased_value, [23:19] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N1 = TABLE_SIZE - 1;
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int KW = $clog2(NEWTON_STEPS + 1);
  localparam int NW = cbe_pkg::DIV_NW;
  localparam int DW = cbe_pkg::DIV_DW;
  localparam int AW = cbe_pkg::MUL_AW;
  localparam int BW = cbe_pkg::MUL_BW;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL, S_FILL_W, S_FILL_WR, S_SEG, S_DOWN_RD, S_DOWN_CHK, S_UP_RD,
    S_UP_CHK, S_LOAD0, S_LOAD1, S_LOAD2, S_DDIV_W, S_TDIV, S_TDIV_W, S_NSLOPE,
    S_NS_CHK, S_NB, S_ND_W, S_YEVAL, S_YFIN, S_EVAL, S_OUT
  } state_t;

  // ---------------- configuration registers
  logic [16:0]        x1, x2;
  logic signed [18:0] y1, y2;
  logic               hold;
  logic               table_ready;
  logic               cfg_wr;
  logic               cfg_known;
  logic               linear;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_known = (paddr[4:2] == cbe_pkg::REG_X1) || (paddr[4:2] == cbe_pkg::REG_Y1) ||
                     (paddr[4:2] == cbe_pkg::REG_X2) || (paddr[4:2] == cbe_pkg::REG_Y2) ||
                     (paddr[4:2] == cbe_pkg::REG_HOLD);
  // linear test is a pure function of the registers
  assign linear = !hold && ({2'b00, x1} == y1) && ({2'b00, x2} == y2);

  always_comb begin
    unique case (paddr[4:2])
      cbe_pkg::REG_X1:   prdata = {15'd0, x1};
      cbe_pkg::REG_Y1:   prdata = {13'd0, y1};
      cbe_pkg::REG_X2:   prdata = {15'd0, x2};
      cbe_pkg::REG_Y2:   prdata = {13'd0, y2};
      cbe_pkg::REG_HOLD: prdata = {31'd0, hold};
      default:           prdata = '0;
    endcase
  end

  // ---------------- sequencer state
  state_t             state, ev_ret;
  logic [16:0]        x;
  logic signed [18:0] res;
  logic [IW-1:0]      gi, fi;
  logic [16:0]        t;
  logic [16:0]        lo;
  logic signed [DW-1:0] slope;
  logic [KW-1:0]      k;
  logic [1:0]         ev_step;
  logic               ev_slope, ev_y;
  logic signed [AW-1:0] ev_res;

  // sample table memory, one registered read port
  logic [16:0]   tbl [TABLE_SIZE];
  logic [IW-1:0] rd_addr;
  logic [16:0]   rd_data;

  // ---------------- shared multiplier
  logic signed [AW-1:0] mul_a, mul_r;
  logic signed [BW-1:0] mul_b;
  logic signed [AW-1:0] a1, a2, c3, c2, c1;

  assign a1 = ev_y ? AW'(y1) : AW'({2'b00, x1});
  assign a2 = ev_y ? AW'(y2) : AW'({2'b00, x2});
  assign c3 = AW'(cbe_pkg::ONE_Q16) - 3 * a2 + 3 * a1;
  assign c2 = 3 * a2 - 6 * a1;
  assign c1 = 3 * a1;
  assign mul_b = BW'({1'b0, t});

  always_comb begin
    case (ev_step)
      2'd0:    mul_a = ev_slope ? 3 * c3 : c3;
      2'd1:    mul_a = mul_r + (ev_slope ? 2 * c2 : c2);
      default: mul_a = mul_r + c1;
    endcase
  end

  cbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .r   (mul_r)
  );

  // ---------------- shared divider
  logic                 div_start, div_busy, div_done;
  logic signed [NW-1:0] div_num, div_quot;
  logic signed [DW-1:0] div_den;
  logic signed [DW-1:0] seg_den;

  assign seg_den = DW'($signed({1'b0, rd_data})) - DW'($signed({1'b0, lo}));

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DW'(N1);
    unique case (state)
      S_LOAD2: begin
        div_start = (seg_den != 0);
        div_num   = NW'($signed({1'b0, x})) - NW'($signed({1'b0, lo}));
        div_num   = div_num <<< 16;
        div_den   = seg_den;
      end
      S_NB: begin
        div_start = 1'b1;
        div_num   = (NW'(ev_res) - NW'($signed({1'b0, x}))) <<< 16;
        div_den   = slope;
      end
      default: ;
    endcase
  end

  cbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------- division by TABLE_SIZE-1
  // g*1.0 + d + N1/2 = g*Q0*N1 + (g*R0 + d + N1/2); the small part m < 2^17 is
  // divided by a reciprocal multiply that is exact over that range.
  localparam int     Q0 = cbe_pkg::ONE_Q16 / N1;
  localparam int     R0 = cbe_pkg::ONE_Q16 % N1;
  localparam int     RS = 17 + $clog2(N1);
  localparam longint RM = ((longint'(1) << RS) + longint'(N1) - 1) / longint'(N1);

  logic [IW-1:0] rq_g;
  logic [16:0]   rq_d;
  logic [16:0]   rq_m, rq_base, rq_quot;
  logic [36:0]   rq_prod;

  assign rq_g    = (state == S_TDIV) ? gi : fi;
  assign rq_d    = (state == S_TDIV) ? t : 17'd0;
  assign rq_prod = 37'(rq_m) * 37'(RM);
  assign rq_quot = 17'(rq_prod >> RS);

  always_ff @(posedge clk) begin
    rq_m    <= 17'(18'(rq_g) * 18'(R0) + 18'(rq_d) + 18'(N1 / 2));
    rq_base <= 17'(18'(rq_g) * 18'(Q0));
  end

  // ---------------- memory
  always_comb begin
    unique case (state)
      S_UP_RD, S_LOAD1: rd_addr = gi + IW'(1);
      default:          rd_addr = gi;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= tbl[rd_addr];
    if (state == S_FILL_WR) begin
      if (ev_res < 0)                  tbl[fi] <= '0;
      else if (ev_res > AW'(131071))   tbl[fi] <= 17'h1FFFF;
      else                             tbl[fi] <= ev_res[16:0];
    end
  end

  // ---------------- helpers
  logic signed [18:0] x_in;
  logic [25:0]        g_est;
  logic signed [NW:0] t_new;

  assign x_in  = $signed(s_tdata[18:0]);
  assign g_est = 26'(x) * 26'(N1);
  assign t_new = (NW + 1)'($signed({1'b0, t})) - (NW + 1)'(div_quot);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'd0, res};

  // ---------------- main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      x1          <= '0;
      y1          <= '0;
      x2          <= 17'(cbe_pkg::ONE_Q16);
      y2          <= 19'(cbe_pkg::ONE_Q16);
      hold        <= 1'b0;
      table_ready <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          cbe_pkg::REG_X1:   x1   <= pwdata[16:0];
          cbe_pkg::REG_Y1:   y1   <= $signed(pwdata[18:0]);
          cbe_pkg::REG_X2:   x2   <= pwdata[16:0];
          cbe_pkg::REG_Y2:   y2   <= $signed(pwdata[18:0]);
          cbe_pkg::REG_HOLD: hold <= pwdata[0];
          default: ;
        endcase
        if (cfg_known) table_ready <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x <= x_in[16:0];
            if (hold || x_in <= 0) begin
              res   <= '0;
              state <= S_OUT;
            end else if (x_in >= 19'sd65536) begin
              res   <= 19'sd65536;
              state <= S_OUT;
            end else if (linear) begin
              res   <= x_in;
              state <= S_OUT;
            end else if (!table_ready) begin
              fi    <= '0;
              state <= S_FILL;
            end else begin
              state <= S_SEG;
            end
          end
        end
        // table build: ti by reciprocal divide, then Bx(ti)
        S_FILL: state <= S_FILL_W;
        S_FILL_W: begin
          t        <= rq_base + rq_quot;
          ev_step  <= 2'd0;
          ev_slope <= 1'b0;
          ev_y     <= 1'b0;
          ev_ret   <= S_FILL_WR;
          state    <= S_EVAL;
        end
        S_FILL_WR: begin
          if (fi == IW'(N1)) begin
            table_ready <= 1'b1;
            state       <= S_SEG;
          end else begin
            fi    <= fi + IW'(1);
            state <= S_FILL;
          end
        end
        // segment search
        S_SEG: begin
          gi    <= IW'(g_est[25:16]);
          state <= S_DOWN_RD;
        end
        S_DOWN_RD: state <= S_DOWN_CHK;
        S_DOWN_CHK: begin
          if (gi != '0 && rd_data > x) begin
            gi    <= gi - IW'(1);
            state <= S_DOWN_RD;
          end else begin
            state <= S_UP_RD;
          end
        end
        S_UP_RD: state <= (gi < IW'(N1 - 1)) ? S_UP_CHK : S_LOAD0;
        S_UP_CHK: begin
          if (rd_data < x) begin
            gi    <= gi + IW'(1);
            state <= S_UP_RD;
          end else begin
            state <= S_LOAD0;
          end
        end
        S_LOAD0: state <= S_LOAD1;
        S_LOAD1: begin
          lo    <= rd_data;
          state <= S_LOAD2;
        end
        S_LOAD2: begin
          // zero-width segment: offset 0
          if (seg_den == 0) begin
            t     <= '0;
            state <= S_TDIV;
          end else begin
            state <= S_DDIV_W;
          end
        end
        S_DDIV_W: begin
          if (div_done) begin
            if (div_quot < 0)                      t <= '0;
            else if (div_quot > NW'(65536))        t <= 17'h10000;
            else                                   t <= div_quot[16:0];
            state <= S_TDIV;
          end
        end
        // first guess t = (g*1.0 + d) / (TABLE_SIZE-1); t holds d here
        S_TDIV: state <= S_TDIV_W;
        S_TDIV_W: begin
          t     <= rq_base + rq_quot;
          k     <= '0;
          state <= S_NSLOPE;
        end
        // Newton refinement
        S_NSLOPE: begin
          ev_step  <= 2'd0;
          ev_slope <= 1'b1;
          ev_y     <= 1'b0;
          ev_ret   <= S_NS_CHK;
          state    <= S_EVAL;
        end
        S_NS_CHK: begin
          if (ev_res <= 0) begin
            state <= S_YEVAL;
          end else begin
            slope    <= ev_res;
            ev_step  <= 2'd0;
            ev_slope <= 1'b0;
            ev_ret   <= S_NB;
            state    <= S_EVAL;
          end
        end
        S_NB: state <= S_ND_W;
        S_ND_W: begin
          if (div_done) begin
            if (t_new < 0)                      t <= '0;
            else if (t_new > (NW + 1)'(65536))  t <= 17'h10000;
            else                                t <= t_new[16:0];
            k <= k + KW'(1);
            state <= (k == KW'(NEWTON_STEPS - 1)) ? S_YEVAL : S_NSLOPE;
          end
        end
        S_YEVAL: begin
          ev_step  <= 2'd0;
          ev_slope <= 1'b0;
          ev_y     <= 1'b1;
          ev_ret   <= S_YFIN;
          state    <= S_EVAL;
        end
        S_YFIN: begin
          if (ev_res < -AW'(131072))     res <= -19'sd131072;
          else if (ev_res > AW'(196608)) res <= 19'sd196608;
          else                           res <= ev_res[18:0];
          state <= S_OUT;
        end
        // polynomial walk on the shared multiplier (Horner form)
        S_EVAL: begin
          ev_step <= ev_step + 2'd1;
          if (ev_slope && ev_step == 2'd2) begin
            ev_res <= mul_r + c1;
            state  <= ev_ret;
          end else if (ev_step == 2'd3) begin
            ev_res <= mul_r;
            state  <= ev_ret;
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst) !(m_tvalid && s_tready))
    else $error("input taken while result pending");
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_known) |=> !table_ready)
    else $error("table not invalidated by register write");
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res >= -19'sd131072 && res <= 19'sd196608))
    else $error("result out of range");
`endif

endmodule
